### rtl/rqr_pkg.sv
// Shared types and constants for the record queue with positional removal.
// Used by the storage cell, the controller, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package rqr_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 8;
  localparam int NAME_W  = 64;
  localparam int LEVEL_W = 8;
  localparam int FACT_W  = 4;

  typedef struct packed {
    logic [NAME_W-1:0]  name;
    logic [LEVEL_W-1:0] level;
    logic [FACT_W-1:0]  faction;
  } rec_t;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_PEEK   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BEYOND = 3'd2,
    ST_BELOW  = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SHIFT = 2'd2
  } cell_op_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FLUSH = 1'b1
  } state_t;

endpackage

`default_nettype wire

### rtl/record_queue_with_positional_removal_unit.sv
// Bounded FIFO of records (name tag, level, faction) held in a chain of DEPTH cells,
// with enqueue, remove at a 1-based position, flush and peek. Enqueue, remove and peek
// are each answered by one result word; a flush emits one word
// per held entry, one per cycle while the result side takes them, since the cell
// chain moves down by one slot per word. No new item is taken during a flush.
`timescale 1ns / 1ps
`default_nettype none

module record_queue_with_positional_removal_unit (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               item_valid,
  output logic                              item_stall,
  input  wire  [1:0]                        mode,
  input  wire  [rqr_pkg::POS_W-1:0]         position,
  input  wire  [rqr_pkg::NAME_W-1:0]        in_name,
  input  wire  [rqr_pkg::LEVEL_W-1:0]       in_level,
  input  wire  [rqr_pkg::FACT_W-1:0]        in_faction,
  output logic                              result_valid,
  input  wire                               result_stall,
  output logic [2:0]                        status,
  output logic                              record_valid,
  output logic [rqr_pkg::NAME_W-1:0]        out_name,
  output logic [rqr_pkg::LEVEL_W-1:0]       out_level,
  output logic [rqr_pkg::FACT_W-1:0]        out_faction,
  output logic [rqr_pkg::CNT_W-1:0]         entry_count,
  output logic                              last
);
  import rqr_pkg::*;

  rec_t     cell_q   [DEPTH];
  rec_t     cell_up  [DEPTH];
  cell_op_t cell_op  [DEPTH];
  rec_t     in_rec;
  rec_t     out_rec;

  assign in_rec.name    = in_name;
  assign in_rec.level   = in_level;
  assign in_rec.faction = in_faction;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g < DEPTH - 1) begin : g_mid
        assign cell_up[g] = cell_q[g+1];
      end else begin : g_top
        assign cell_up[g] = cell_q[g];
      end
      rqr_cell u_cell (
        .clk       (clk),
        .op        (cell_op[g]),
        .load_rec  (in_rec),
        .shift_rec (cell_up[g]),
        .q         (cell_q[g])
      );
    end
  endgenerate

  rqr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .position     (position),
    .head_rec     (cell_q[0]),
    .cell_op      (cell_op),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .record_valid (record_valid),
    .out_rec      (out_rec),
    .entry_count  (entry_count),
    .last         (last)
  );

  assign out_name    = out_rec.name;
  assign out_level   = out_rec.level;
  assign out_faction = out_rec.faction;

endmodule

`default_nettype wire

### rtl/rqr_cell.sv
// One storage cell of the queue chain: holds one record.
// Loads a new record, takes its upper neighbor's record, or holds. Uses rqr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqr_cell (
  input  wire               clk,
  input  rqr_pkg::cell_op_t op,
  input  rqr_pkg::rec_t     load_rec,
  input  rqr_pkg::rec_t     shift_rec,
  output rqr_pkg::rec_t     q
);
  import rqr_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD:  q <= load_rec;
      OP_SHIFT: q <= shift_rec;
      default:  q <= q;
    endcase
  end

endmodule

`default_nettype wire

### rtl/rqr_ctrl.sv
// Controller of the record queue: entry count, flush sequencer, per-cell
// commands and the registered result word. Uses rqr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqr_ctrl (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          item_valid,
  output logic                         item_stall,
  input  wire  [1:0]                   mode,
  input  wire  [rqr_pkg::POS_W-1:0]    position,
  input  rqr_pkg::rec_t                head_rec,
  output rqr_pkg::cell_op_t            cell_op [rqr_pkg::DEPTH],
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic [2:0]                   status,
  output logic                         record_valid,
  output rqr_pkg::rec_t                out_rec,
  output logic [rqr_pkg::CNT_W-1:0]    entry_count,
  output logic                         last
);
  import rqr_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             acc, out_free, res_load;
  mode_t            md;
  status_t          status_next;
  logic             rv_next, last_next;
  rec_t             rec_next;
  logic [CNT_W-1:0] ec_next;
  logic             is_empty, is_full;

  assign md       = mode_t'(mode);
  assign out_free = !result_valid || !result_stall;
  assign item_stall = (state != S_IDLE) || !out_free;
  assign acc      = item_valid && !item_stall;
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(DEPTH));
  assign res_load = acc || ((state == S_FLUSH) && out_free);

  // Next state of the flush sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && md == MODE_FLUSH && count > CNT_W'(1)) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (out_free && count == CNT_W'(1)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Cell commands, count update and the next result word.
  always_comb begin
    status_next = ST_OK;
    rv_next     = 1'b0;
    rec_next    = '0;
    last_next   = 1'b1;
    count_next  = count;
    for (int i = 0; i < DEPTH; i++) cell_op[i] = OP_HOLD;

    if ((state == S_FLUSH && out_free) ||
        (acc && md == MODE_FLUSH && !is_empty)) begin
      // One flush step: emit the head and move every cell down by one.
      rv_next    = 1'b1;
      rec_next   = head_rec;
      count_next = count - CNT_W'(1);
      last_next  = (count == CNT_W'(1));
      for (int i = 0; i < DEPTH; i++) cell_op[i] = OP_SHIFT;
    end else if (acc) begin
      unique case (md)
        MODE_ENQ: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (CNT_W'(i) == count) cell_op[i] = OP_LOAD;
            end
            count_next = count + CNT_W'(1);
          end
        end
        MODE_REMOVE: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else if (position > POS_W'(count)) begin
            status_next = ST_BEYOND;
          end else if (position == '0) begin
            status_next = ST_BELOW;
          end else begin
            // Cells from the removed slot up to the one below the tail take their upper neighbor.
            for (int i = 0; i < DEPTH; i++) begin
              if (POS_W'(i) >= position - POS_W'(1) &&
                  POS_W'(i) + POS_W'(1) < POS_W'(count)) begin
                cell_op[i] = OP_SHIFT;
              end
            end
            count_next = count - CNT_W'(1);
          end
        end
        MODE_FLUSH: begin
          status_next = ST_EMPTY;
        end
        MODE_PEEK: begin
          if (is_empty) begin
            status_next = ST_EMPTY;
          end else begin
            rv_next  = 1'b1;
            rec_next = head_rec;
          end
        end
        default: status_next = ST_OK;
      endcase
    end
    ec_next = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status       <= status_next;
      record_valid <= rv_next;
      out_rec      <= rec_next;
      entry_count  <= ec_next;
      last         <= last_next;
    end
  end

endmodule

`default_nettype wire

### rtl/rqr_checker.sv
// Port-level checks for the record queue top level, attached by a bind statement.
// Uses rqr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rqr_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          item_stall,
  input wire                          result_valid,
  input wire                          result_stall,
  input wire [2:0]                    status,
  input wire                          record_valid,
  input wire [rqr_pkg::NAME_W-1:0]    out_name,
  input wire [rqr_pkg::LEVEL_W-1:0]   out_level,
  input wire [rqr_pkg::FACT_W-1:0]    out_faction,
  input wire [rqr_pkg::CNT_W-1:0]     entry_count,
  input wire                          last
);
  import rqr_pkg::*;

  // The count never goes past the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> entry_count <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  // A word without a record carries zero record fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !record_valid) |->
      (out_name == '0 && out_level == '0 && out_faction == '0))
    else $error("record fields not zero");

  // Error words end their item and carry no record.
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != ST_OK) |-> (last && !record_valid))
    else $error("error word not final");

  // Once a non-final flush word is taken, the next one follows with one less.
  a_flush_next: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && !last) |=>
      (result_valid && record_valid && entry_count == $past(entry_count) - CNT_W'(1)))
    else $error("flush sequence broken");

  // No new item is taken while a flush is still under way.
  a_flush_blocks: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> item_stall)
    else $error("input taken during flush");

endmodule

bind record_queue_with_positional_removal_unit rqr_checker u_rqr_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for record_queue_with_positional_removal_unit.
// It needs rqr_pkg and the unit itself, and it keeps its own copy of the queue to predict
// every result word.
`timescale 1ns / 1ps

module tb_top;
  import rqr_pkg::*;

  typedef struct {
    status_t           status;
    logic              has_rec;
    rec_t              rec;
    logic [CNT_W-1:0]  count;
    logic              last;
  } reply_t;

  class roster_tracker;
    rec_t   roster[$];
    reply_t pending_replies[$];
    int     errors = 0;

    function void accept_request(mode_t op, logic [POS_W-1:0] pos, rec_t rec);
      reply_t r;
      int n;
      r.status = ST_OK;
      r.has_rec = 1'b0;
      r.rec = '0;
      r.last = 1'b1;
      n = roster.size();
      case (op)
        MODE_ENQ: begin
          if (n >= DEPTH) r.status = ST_FULL;
          else roster.insert(roster.size(), rec);
        end
        MODE_REMOVE: begin
          if (n == 0) r.status = ST_EMPTY;
          else if (pos > n) r.status = ST_BEYOND;
          else if (pos == 0) r.status = ST_BELOW;
          else roster.delete(pos - 1);
        end
        MODE_FLUSH: begin
          if (n == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // One word per entry, head first, counting down to zero.
            for (int i = 0; i < n; i++) begin
              r.has_rec = 1'b1;
              r.rec = roster[i];
              r.count = CNT_W'(n - 1 - i);
              r.last = (i == n - 1);
              pending_replies.insert(pending_replies.size(), r);
            end
            roster.delete();
            return;
          end
        end
        MODE_PEEK: begin
          if (n == 0) r.status = ST_EMPTY;
          else begin
            r.has_rec = 1'b1;
            r.rec = roster[0];
          end
        end
        default: return;
      endcase
      r.count = CNT_W'(roster.size());
      pending_replies.insert(pending_replies.size(), r);
    endfunction

    function void compare(string field, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
        errors++;
      end
    endfunction

    function void match_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual status %0d count %0d",
                 $time, got.status, got.count);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      compare("status", want.status, got.status);
      compare("record_valid", want.has_rec, got.has_rec);
      compare("out_name", want.rec.name, got.rec.name);
      compare("out_level", want.rec.level, got.rec.level);
      compare("out_faction", want.rec.faction, got.rec.faction);
      compare("entry_count", want.count, got.count);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [1:0]          mode = MODE_ENQ;
  logic [POS_W-1:0]    position = '0;
  logic [NAME_W-1:0]   in_name = '0;
  logic [LEVEL_W-1:0]  in_level = '0;
  logic [FACT_W-1:0]   in_faction = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [2:0]          status;
  logic                record_valid;
  logic [NAME_W-1:0]   out_name;
  logic [LEVEL_W-1:0]  out_level;
  logic [FACT_W-1:0]   out_faction;
  logic [CNT_W-1:0]    entry_count;
  logic                last;

  int idle_pct = 0;
  int stall_pct = 0;

  roster_tracker tracker = new();

  record_queue_with_positional_removal_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (mode),
    .position     (position),
    .in_name      (in_name),
    .in_level     (in_level),
    .in_faction   (in_faction),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .record_valid (record_valid),
    .out_name     (out_name),
    .out_level    (out_level),
    .out_faction  (out_faction),
    .entry_count  (entry_count),
    .last         (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Requests are noted before results; results are registered, so each answer finds its expectation queued.
  always @(posedge clk) begin : monitor
    rec_t   req;
    reply_t got;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        req.name = in_name;
        req.level = in_level;
        req.faction = in_faction;
        tracker.accept_request(mode_t'(mode), position, req);
      end
      if (result_valid && !result_stall) begin
        got.status = status_t'(status);
        got.has_rec = record_valid;
        got.rec.name = out_name;
        got.rec.level = out_level;
        got.rec.faction = out_faction;
        got.count = entry_count;
        got.last = last;
        tracker.match_reply(got);
      end
    end
  end

  task automatic issue_request(mode_t op, logic [POS_W-1:0] pos, rec_t rec);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= op;
    position <= pos;
    in_name <= rec.name;
    in_level <= rec.level;
    in_faction <= rec.faction;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    rec_t   rec;
    mode_t  op;
    logic [POS_W-1:0] pos;
    int     held;
    int     roll;
    bit     filling;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty-queue cases for every mode that reads the queue.
    issue_request(MODE_PEEK, 8'd0, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_FLUSH, 8'd0, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd0, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd255, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_ENQ, 8'd255, '{{64{1'b1}}, 8'hff, 4'hf});
    issue_request(MODE_ENQ, 8'd0, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_PEEK, 8'd0, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd0, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd3, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd2, '{64'h0, 8'h0, 4'h0});
    // Removing the sole entry must leave no stale tail behind the next enqueue.
    issue_request(MODE_REMOVE, 8'd1, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_PEEK, 8'd0, '{64'h0, 8'h0, 4'h0});
    for (int i = 0; i <= DEPTH; i++)
      issue_request(MODE_ENQ, 8'd0, '{{$urandom(), $urandom()}, 8'(i), 4'(i)});
    issue_request(MODE_REMOVE, 8'(DEPTH), '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd5, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_REMOVE, 8'd1, '{64'h0, 8'h0, 4'h0});
    issue_request(MODE_FLUSH, 8'd0, '{64'h0, 8'h0, 4'h0});

    filling = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      for (int k = 0; k < 100; k++) begin
        // The queue grows in fill stretches and shrinks in drain stretches, so it
        // regularly reaches both full and empty.
        if ($urandom_range(9) == 0) filling = !filling;
        held = tracker.roster.size();
        roll = $urandom_range(99);
        if (roll < (filling ? 75 : 30)) op = MODE_ENQ;
        else if (roll < (filling ? 88 : 78)) op = MODE_REMOVE;
        else if (roll < (filling ? 90 : 84)) op = MODE_FLUSH;
        else op = MODE_PEEK;
        roll = $urandom_range(99);
        if (op == MODE_REMOVE && held > 0 && roll < 70) pos = 8'($urandom_range(held, 1));
        else if (roll < 78) pos = 8'd0;
        else pos = 8'($urandom_range(255));
        rec.name = {$urandom(), $urandom()};
        rec.level = 8'($urandom_range(255));
        rec.faction = 4'($urandom_range(15));
        issue_request(op, pos, rec);
      end
    end
    item_valid <= 1'b0;
    // Let the monitor note the last accepted word before the queue is polled.
    @(posedge clk);

    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

### files.f
rtl/rqr_pkg.sv
rtl/rqr_cell.sv
rtl/rqr_ctrl.sv
rtl/record_queue_with_positional_removal_unit.sv
rtl/rqr_checker.sv
verif/tb_top.sv
